// File: design/task_queue_policy_select_assert.svh
// Assertion macros used by the checker file.
`ifndef TASK_QUEUE_POLICY_SELECT_ASSERT_SVH
`define TASK_QUEUE_POLICY_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TQPS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TQPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/tqps_pkg.sv
// ----------------------------------------------------------------------------
// tqps_pkg
// Types, codes and helpers shared by the task queue policy select block.
// ----------------------------------------------------------------------------
package tqps_pkg;

    localparam int Q_DEPTH  = 16;
    localparam int W_WEIGHT = 38;

    typedef enum logic [2:0] {
        POL_LIFO   = 3'd0,
        POL_FIFO   = 3'd1,
        POL_PRIO   = 3'd2,
        POL_MULTI  = 3'd3,
        POL_LEVEL  = 3'd4,
        POL_WEIGHT = 3'd5
    } t_policy;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_NONE   = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_POLICY = 2'd0,
        CFG_HIGH   = 2'd1,
        CFG_MID    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PMUL,
        S_PWR,
        S_SCAN,
        S_PICK
    } t_state;

    typedef struct packed {
        logic [15:0]         id;
        logic [7:0]          prio;
        logic [15:0]         count;
        logic [15:0]         conn;
        logic [15:0]         sub;
        logic [15:0]         proc_cnt;
        logic [31:0]         mem;
        logic [31:0]         disc;
        logic                res;
        logic [W_WEIGHT-1:0] weight;
    } t_entry;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_cell_ctl;

    function automatic logic [1:0] level_of(input logic [7:0] prio,
                                            input logic [7:0] hi,
                                            input logic [7:0] mid);
        logic [1:0] lvl;
        if (prio >= hi) begin
            lvl = 2'd0;
        end else if (prio >= mid) begin
            lvl = 2'd1;
        end else begin
            lvl = 2'd2;
        end
        return lvl;
    endfunction

endpackage

// File: design/tqps_cell.sv
// ----------------------------------------------------------------------------
// tqps_cell
// One slot of the task store: loads a pushed item or its right neighbour.
// ----------------------------------------------------------------------------
module tqps_cell (
    input  logic               i_clk,
    input  tqps_pkg::t_cell_ctl i_ctl,
    input  tqps_pkg::t_entry   i_push,
    input  tqps_pkg::t_entry   i_next,
    output tqps_pkg::t_entry   o_entry
);
    import tqps_pkg::*;

    t_entry r_entry;

    // take the tail write, else close the gap from the neighbour, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_entry <= i_push;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: design/task_queue_policy_select.sv
// Push: accepted, then S_PMUL (product) and S_PWR (weight and tail write); result strobed after S_PWR.
// Pop: the scan reads one stored cell per cycle in order, then S_PICK strobes the result.
// Store full, or pop of an empty store: result strobed on the cycle after accept.
// One item at a time: the next is taken after the strobe.
// Synchronous active-low reset empties the store and reloads policy 1, thresholds 10 and 5.
// ----------------------------------------------------------------------------
// task_queue_policy_select
// Ordered task store held in a chain of cells, with a configurable pick
// policy. Push appends at the tail; pop scans the chain, picks one item and
// shifts the later cells down by one to close the gap.
// ----------------------------------------------------------------------------
module task_queue_policy_select #(
    parameter int QUEUE_DEPTH = tqps_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_count,
    input  logic [15:0] i_connectivity,
    input  logic [15:0] i_subtask_size,
    input  logic [15:0] i_proc_count,
    input  logic [31:0] i_mem_size,
    input  logic [31:0] i_disc_size,
    input  logic        i_has_resource,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_task_id,
    output logic [7:0]  o_out_priority,
    output logic [15:0] o_out_count,
    output logic [15:0] o_out_connectivity,
    output logic [15:0] o_out_subtask_size,
    output logic [15:0] o_out_proc_count,
    output logic [31:0] o_out_mem_size,
    output logic [31:0] o_out_disc_size
);
    import tqps_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [2:0] r_policy;
    logic [7:0] r_high;
    logic [7:0] r_mid;

    // control
    t_state        r_state, n_state;
    logic [CW-1:0] r_total;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_sel;
    logic          r_found;
    logic [1:0]    r_best_lvl;
    t_entry        r_best;
    logic          r_valid;

    // captured push item and partial product
    t_entry      r_in;
    logic [31:0] r_prod;

    // result
    logic [1:0] r_status;
    t_entry     r_res;

    // cell chain
    t_entry    w_cells [QUEUE_DEPTH];
    t_cell_ctl w_ctl   [QUEUE_DEPTH];
    t_entry    w_push;
    t_entry    w_cur;
    logic [1:0] w_cur_lvl;
    logic      w_take;
    logic      w_accept;
    logic      w_scan_end;
    logic      w_full;

    assign w_accept   = start && !busy;
    assign w_full     = (r_total == CW'(QUEUE_DEPTH));
    assign w_scan_end = (CW'(r_idx) == r_total - 1'b1);
    assign busy       = (r_state != S_IDLE) || r_valid;

    // configuration writes; unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 3'(POL_FIFO);
            r_high   <= 8'd10;
            r_mid    <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[2:0];
                CFG_HIGH:   r_high   <= i_cfg_data;
                CFG_MID:    r_mid    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_PUSH) begin
                        n_state = w_full ? S_IDLE : S_PMUL;
                    end else begin
                        n_state = (r_total == '0) ? S_IDLE : S_SCAN;
                    end
                end
            end
            S_PMUL:  n_state = S_PWR;
            S_PWR:   n_state = S_IDLE;
            S_SCAN:  n_state = w_scan_end ? S_PICK : S_SCAN;
            S_PICK:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // the cell under the scan pointer, and whether it becomes the choice
    assign w_cur     = w_cells[r_idx];
    assign w_cur_lvl = level_of(w_cur.prio, r_high, r_mid);

    always_comb begin
        case (r_policy)
            POL_LIFO:   w_take = 1'b1;
            POL_FIFO:   w_take = !r_found;
            POL_PRIO:   w_take = !r_found || (w_cur.prio > r_best.prio);
            POL_MULTI:  w_take = !r_found || (w_cur.count > r_best.count) ||
                                 (w_cur.conn > r_best.conn) || (w_cur.sub > r_best.sub);
            POL_LEVEL:  w_take = !r_found || (w_cur_lvl < r_best_lvl);
            POL_WEIGHT: w_take = w_cur.res && (!r_found || (w_cur.weight < r_best.weight));
            default:    w_take = 1'b0;
        endcase
    end

    // weight = 6*count*proc + 8*mem + disc, formed from the registered product
    always_comb begin
        w_push        = r_in;
        w_push.weight = (W_WEIGHT'(r_prod) << 2) + (W_WEIGHT'(r_prod) << 1) +
                        (W_WEIGHT'(r_in.mem) << 3) + W_WEIGHT'(r_in.disc);
    end

    // cell controls: write at the tail, shift down at and above the picked slot
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_ctl[i].wr    = (r_state == S_PWR) && (CW'(i) == r_total);
            w_ctl[i].shift = (r_state == S_PICK) && r_found && (IW'(i) >= r_sel);
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == QUEUE_DEPTH - 1) begin : g_last
            tqps_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_push  (w_push),
                .i_next  (w_cells[g]),
                .o_entry (w_cells[g])
            );
        end else begin : g_mid
            tqps_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_push  (w_push),
                .i_next  (w_cells[g+1]),
                .o_entry (w_cells[g])
            );
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_found <= 1'b0;
                        if (i_command == CMD_PUSH) begin
                            r_valid <= w_full;
                        end else begin
                            r_valid <= (r_total == '0);
                        end
                    end
                end
                S_PWR: begin
                    r_total <= r_total + 1'b1;
                    r_valid <= 1'b1;
                end
                S_SCAN: begin
                    if (w_take) begin
                        r_found <= 1'b1;
                    end
                end
                S_PICK: begin
                    r_valid <= 1'b1;
                    if (r_found) begin
                        r_total <= r_total - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: capture, scan pointer, best-so-far and result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx <= '0;
                r_res <= '0;
                if (w_accept) begin
                    r_in.id       <= i_task_id;
                    r_in.prio     <= i_priority_req;
                    r_in.count    <= i_count;
                    r_in.conn     <= i_connectivity;
                    r_in.sub      <= i_subtask_size;
                    r_in.proc_cnt <= i_proc_count;
                    r_in.mem      <= i_mem_size;
                    r_in.disc     <= i_disc_size;
                    r_in.res      <= i_has_resource;
                    r_in.weight   <= '0;
                    if (i_command == CMD_PUSH) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_status <= ST_NONE;
                    end
                end
            end
            S_PMUL: begin
                r_prod <= 32'(r_in.count * r_in.proc_cnt);
            end
            S_PWR: begin
                r_status <= ST_PUSHED;
                r_res    <= '0;
            end
            S_SCAN: begin
                r_idx <= r_idx + 1'b1;
                if (w_take) begin
                    r_sel      <= r_idx;
                    r_best     <= w_cur;
                    r_best_lvl <= w_cur_lvl;
                end
            end
            S_PICK: begin
                if (r_found) begin
                    r_status <= ST_POPPED;
                    r_res    <= r_best;
                end else begin
                    r_status <= ST_NONE;
                    r_res    <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_out_task_id      = r_res.id;
    assign o_out_priority     = r_res.prio;
    assign o_out_count        = r_res.count;
    assign o_out_connectivity = r_res.conn;
    assign o_out_subtask_size = r_res.sub;
    assign o_out_proc_count   = r_res.proc_cnt;
    assign o_out_mem_size     = r_res.mem;
    assign o_out_disc_size    = r_res.disc;

endmodule

// File: design/tqps_checker.sv
// ----------------------------------------------------------------------------
// tqps_checker
// Port-level checks on the task queue policy select block.
// ----------------------------------------------------------------------------
`include "task_queue_policy_select_assert.svh"

module tqps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [15:0] o_out_task_id,
    input logic [31:0] o_out_mem_size
);
    import tqps_pkg::*;

    logic w_no_item;
    logic w_fields_zero;

    assign w_no_item     = o_valid && (o_status != ST_POPPED);
    assign w_fields_zero = (o_out_task_id == 16'd0) && (o_out_mem_size == 32'd0);

    `TQPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TQPS_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid)
    `TQPS_ASSERT_SAME(a_strobe_busy, o_valid, busy)
    `TQPS_ASSERT_SAME(a_empty_fields, w_no_item, w_fields_zero)

endmodule

bind task_queue_policy_select tqps_checker u_tqps_checker (.*);
